// File: design/npl_pkg.sv
// npl_pkg: shared types and constants for the node pool depth-list manager
// no dependencies; imported by every module of the block

package npl_pkg;

    // default sizing of the pool and the number of depth lists
    localparam int POOL_NODES_DEF   = 256;
    localparam int DEPTH_LEVELS_DEF = 10;

    // port field widths
    localparam int CMD_W    = 1;
    localparam int PARENT_W = 9;
    localparam int TARGET_W = 8;
    localparam int NODE_W   = 8;
    localparam int LEVEL_W  = 4;
    localparam int PREV_W   = 9;
    localparam int STATUS_W = 2;

    // command codes
    typedef enum logic [CMD_W-1:0] {
        CMD_ALLOC = 1'b0,
        CMD_FREE  = 1'b1
    } cmd_t;

    // result status codes
    typedef enum logic [STATUS_W-1:0] {
        ST_ALLOC = 2'd0,
        ST_FREED = 2'd1,
        ST_EMPTY = 2'd2,
        ST_DEEP  = 2'd3
    } status_t;

    // classified command as it travels from the front end to the back end
    typedef struct packed {
        cmd_t                op;
        logic [PARENT_W-1:0] parent;
        logic                parent_root;
        logic [TARGET_W-1:0] target;
        logic                target_ok;
    } item_t;

endpackage

// File: design/node_pool_depth_lists_top.sv
// node_pool_depth_lists_top: node pool manager with a LIFO free list and one
// doubly linked list per depth level. depends on npl_pkg, npl_front,
// npl_queue and npl_back
//
// Usage:
//   request channel (req_valid / req_stall): cmd 0 allocates a node under
//   parent_node (POOL_NODES or above is the root), cmd 1 frees target_node.
//   response channel (rsp_valid / rsp_stall): one transaction per request,
//   in request order, carrying new_node, node_level, prev_in_level, status.
//   Each command reads the node link memories as it leaves the queue, then
//   writes them back and registers its response in the execute state; a new
//   command is not taken until the previous one has written back.
//   A two-entry queue sits behind the request port, so requests keep being
//   taken while a response waits; req_stall rises only when it is full.
//   When rsp_stall is held, the response holds and the pipeline stops once
//   the queue fills.
//   Reset: the free list starts as 0, 1, 2 and so on (tracked by a fresh
//   count, no memory sweep), all depth lists are empty, and requests are
//   taken as soon as reset is released.

module node_pool_depth_lists_top #(
    parameter int POOL_NODES   = npl_pkg::POOL_NODES_DEF,
    parameter int DEPTH_LEVELS = npl_pkg::DEPTH_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [npl_pkg::CMD_W-1:0]     cmd,
    input  logic [npl_pkg::PARENT_W-1:0]  parent_node,
    input  logic [npl_pkg::TARGET_W-1:0]  target_node,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [npl_pkg::NODE_W-1:0]    new_node,
    output logic [npl_pkg::LEVEL_W-1:0]   node_level,
    output logic [npl_pkg::PREV_W-1:0]    prev_in_level,
    output logic [npl_pkg::STATUS_W-1:0]  status
);
    import npl_pkg::*;

    logic  q_full;
    logic  push;
    item_t push_item;
    logic  pop;
    logic  q_valid;
    item_t q_item;

    // accept and classify requests
    npl_front #(
        .POOL_NODES (POOL_NODES)
    ) u_front (
        .req_valid   (req_valid),
        .req_stall   (req_stall),
        .cmd         (cmd),
        .parent_node (parent_node),
        .target_node (target_node),
        .q_full      (q_full),
        .push        (push),
        .push_item   (push_item)
    );

    // decoupling queue
    npl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (q_full),
        .pop       (pop),
        .q_valid   (q_valid),
        .q_item    (q_item)
    );

    // execution and response
    npl_back #(
        .POOL_NODES   (POOL_NODES),
        .DEPTH_LEVELS (DEPTH_LEVELS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .q_valid       (q_valid),
        .q_item        (q_item),
        .pop           (pop),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .new_node      (new_node),
        .node_level    (node_level),
        .prev_in_level (prev_in_level),
        .status        (status)
    );

endmodule

// File: design/npl_front.sv
// npl_front: request acceptance and command classification
// depends on npl_pkg; feeds npl_queue

module npl_front #(
    parameter int POOL_NODES = npl_pkg::POOL_NODES_DEF
) (
    input  logic                          req_valid,
    output logic                          req_stall,
    input  logic [npl_pkg::CMD_W-1:0]     cmd,
    input  logic [npl_pkg::PARENT_W-1:0]  parent_node,
    input  logic [npl_pkg::TARGET_W-1:0]  target_node,
    input  logic                          q_full,
    output logic                          push,
    output npl_pkg::item_t                push_item
);
    import npl_pkg::*;

    // hold off the sender while the queue has no room
    assign req_stall = q_full;
    assign push      = req_valid && !q_full;

    // decode the command and range-check its node indices
    always_comb
    begin
        push_item.op          = cmd_t'(cmd);
        push_item.parent      = parent_node;
        push_item.parent_root = 32'(parent_node) >= 32'(POOL_NODES);
        push_item.target      = target_node;
        push_item.target_ok   = 32'(target_node) < 32'(POOL_NODES);
    end

endmodule

// File: design/npl_queue.sv
// npl_queue: two-entry queue between the front end and the back end
// depends on npl_pkg for the item type

module npl_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  npl_pkg::item_t push_item,
    output logic           full,
    input  logic           pop,
    output logic           q_valid,
    output npl_pkg::item_t q_item
);
    import npl_pkg::*;

    localparam int QUEUE_DEPTH = 2;
    localparam int PTR_W       = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

    item_t            entry_mem [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full    = count_reg == CNT_W'(QUEUE_DEPTH);
    assign q_valid = count_reg != '0;
    assign q_item  = entry_mem[rd_ptr_reg];

    // entry storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_mem[wr_ptr_reg] <= push_item;
        end
    end

    // pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + PTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + PTR_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - CNT_W'(1);
            end
        end
    end

endmodule

// File: design/npl_back.sv
// npl_back: link memories, free list and depth lists; executes one command
// at a time and holds the result register. depends on npl_pkg

module npl_back #(
    parameter int POOL_NODES   = npl_pkg::POOL_NODES_DEF,
    parameter int DEPTH_LEVELS = npl_pkg::DEPTH_LEVELS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          q_valid,
    input  npl_pkg::item_t                q_item,
    output logic                          pop,
    output logic                          rsp_valid,
    input  logic                          rsp_stall,
    output logic [npl_pkg::NODE_W-1:0]    new_node,
    output logic [npl_pkg::LEVEL_W-1:0]   node_level,
    output logic [npl_pkg::PREV_W-1:0]    prev_in_level,
    output logic [npl_pkg::STATUS_W-1:0]  status
);
    import npl_pkg::*;

    localparam int IW = $clog2(POOL_NODES);
    localparam int LW = $clog2(POOL_NODES + 1);
    localparam int DW = $clog2(DEPTH_LEVELS);
    localparam logic [LW-1:0] NONE = LW'(POOL_NODES);

    typedef enum logic {
        S_IDLE,
        S_EXEC
    } state_t;

    // node memories, not cleared at reset; an unwritten free link is never looked at
    logic [LW-1:0] free_link_mem [POOL_NODES];
    logic [LW-1:0] prev_mem      [POOL_NODES];
    logic [LW-1:0] next_mem      [POOL_NODES];
    logic [DW-1:0] depth_mem     [POOL_NODES];
    logic          used_mem      [POOL_NODES];

    // registered read data
    logic [LW-1:0] flink_rd_reg;
    logic [LW-1:0] prev_rd_reg;
    logic [LW-1:0] next_rd_reg;
    logic [DW-1:0] depth_rd_reg;
    logic          used_rd_reg;

    // free list head, fresh-node count and depth list ends
    logic [LW-1:0] free_head_reg, free_head_next;
    logic [LW-1:0] fresh_reg, fresh_next;
    logic [LW-1:0] level_first_reg [DEPTH_LEVELS];
    logic [LW-1:0] level_last_reg  [DEPTH_LEVELS];

    // control and result registers
    state_t              state_reg;
    item_t               item_reg;
    logic                out_valid_reg;
    logic [NODE_W-1:0]   new_node_reg;
    logic [LEVEL_W-1:0]  node_level_reg;
    logic [PREV_W-1:0]   prev_reg;
    status_t             status_reg;

    // read addresses
    logic [IW-1:0] head_idx;
    logic [IW-1:0] tgt_raddr;
    logic [IW-1:0] dep_raddr;

    // execute-stage decode
    logic          fire;
    logic          is_alloc;
    logic [DW-1:0] pdepth;
    logic [DW:0]   ndepth;
    logic [DW-1:0] a_didx;
    logic [LW-1:0] a_last;
    logic          pool_empty;
    logic          too_deep;
    logic          fresh_hit;
    logic [LW-1:0] head_inc;
    logic          alloc_ok;
    logic [LW-1:0] t_lw;
    logic [IW-1:0] t_idx;
    logic [DW-1:0] f_didx;
    logic [LW-1:0] f_prev;
    logic [LW-1:0] f_next;
    logic          free_ok;

    // write controls
    logic          flink_we;
    logic [IW-1:0] flink_waddr;
    logic [LW-1:0] flink_wdata;
    logic          prev_we;
    logic [IW-1:0] prev_waddr;
    logic [LW-1:0] prev_wdata;
    logic          next_we;
    logic [IW-1:0] next_waddr;
    logic [LW-1:0] next_wdata;
    logic          dep_we;
    logic [IW-1:0] dep_waddr;
    logic [DW-1:0] dep_wdata;
    logic          used_we;
    logic [IW-1:0] used_waddr;
    logic          used_wdata;
    logic          lf_we;
    logic [DW-1:0] lf_idx;
    logic [LW-1:0] lf_data;
    logic          ll_we;
    logic [DW-1:0] ll_idx;
    logic [LW-1:0] ll_data;

    // take a new command only when the previous one has written back
    assign pop       = (state_reg == S_IDLE) && q_valid;
    assign head_idx  = free_head_reg[IW-1:0];
    assign tgt_raddr = IW'(q_item.target);
    assign dep_raddr = (q_item.op == CMD_ALLOC) ? IW'(q_item.parent) : tgt_raddr;

    // execute-stage decode of the held command and read data
    always_comb
    begin
        fire       = (state_reg == S_EXEC) && !(out_valid_reg && rsp_stall);
        is_alloc   = item_reg.op == CMD_ALLOC;
        pdepth     = item_reg.parent_root ? '0 : depth_rd_reg;
        ndepth     = (DW+1)'(pdepth) + (DW+1)'(1);
        a_didx     = ndepth[DW-1:0];
        a_last     = level_last_reg[a_didx];
        pool_empty = free_head_reg == NONE;
        too_deep   = 32'(ndepth) >= 32'(DEPTH_LEVELS);
        fresh_hit  = free_head_reg >= fresh_reg;
        head_inc   = free_head_reg + LW'(1);
        alloc_ok   = is_alloc && !pool_empty && !too_deep;
        t_lw       = LW'(item_reg.target);
        t_idx      = IW'(item_reg.target);
        f_didx     = depth_rd_reg;
        f_prev     = (level_first_reg[f_didx] == t_lw) ? NONE : prev_rd_reg;
        f_next     = (level_last_reg[f_didx] == t_lw) ? NONE : next_rd_reg;
        free_ok    = !is_alloc && item_reg.target_ok && (t_lw < fresh_reg) && used_rd_reg;
    end

    // memory and list updates for the executing command
    always_comb
    begin
        flink_we       = 1'b0;
        flink_waddr    = t_idx;
        flink_wdata    = free_head_reg;
        prev_we        = 1'b0;
        prev_waddr     = head_idx;
        prev_wdata     = a_last;
        next_we        = 1'b0;
        next_waddr     = a_last[IW-1:0];
        next_wdata     = free_head_reg;
        dep_we         = 1'b0;
        dep_waddr      = head_idx;
        dep_wdata      = a_didx;
        used_we        = 1'b0;
        used_waddr     = head_idx;
        used_wdata     = 1'b1;
        lf_we          = 1'b0;
        lf_idx         = a_didx;
        lf_data        = free_head_reg;
        ll_we          = 1'b0;
        ll_idx         = a_didx;
        ll_data        = free_head_reg;
        free_head_next = free_head_reg;
        fresh_next     = fresh_reg;
        if (fire && alloc_ok)
        begin
            // pop the free head, append it to the tail of its depth list
            dep_we   = 1'b1;
            used_we  = 1'b1;
            prev_we  = 1'b1;
            ll_we    = 1'b1;
            if (a_last != NONE)
            begin
                next_we = 1'b1;
            end
            else
            begin
                lf_we = 1'b1;
            end
            free_head_next = fresh_hit ? head_inc : flink_rd_reg;
            fresh_next     = fresh_hit ? head_inc : fresh_reg;
        end
        else if (fire && free_ok)
        begin
            // unlink from the depth list, push onto the free list
            if (f_prev != NONE)
            begin
                next_we    = 1'b1;
                next_waddr = f_prev[IW-1:0];
                next_wdata = f_next;
            end
            else
            begin
                lf_we   = 1'b1;
                lf_idx  = f_didx;
                lf_data = f_next;
            end
            if (f_next != NONE)
            begin
                prev_we    = 1'b1;
                prev_waddr = f_next[IW-1:0];
                prev_wdata = f_prev;
            end
            else
            begin
                ll_we   = 1'b1;
                ll_idx  = f_didx;
                ll_data = f_prev;
            end
            used_we        = 1'b1;
            used_waddr     = t_idx;
            used_wdata     = 1'b0;
            flink_we       = 1'b1;
            free_head_next = t_lw;
        end
    end

    // node memories: read at pop, written at execute
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            flink_rd_reg <= free_link_mem[head_idx];
            depth_rd_reg <= depth_mem[dep_raddr];
            prev_rd_reg  <= prev_mem[tgt_raddr];
            next_rd_reg  <= next_mem[tgt_raddr];
            used_rd_reg  <= used_mem[tgt_raddr];
        end
        if (flink_we)
        begin
            free_link_mem[flink_waddr] <= flink_wdata;
        end
        if (prev_we)
        begin
            prev_mem[prev_waddr] <= prev_wdata;
        end
        if (next_we)
        begin
            next_mem[next_waddr] <= next_wdata;
        end
        if (dep_we)
        begin
            depth_mem[dep_waddr] <= dep_wdata;
        end
        if (used_we)
        begin
            used_mem[used_waddr] <= used_wdata;
        end
    end

    // free list head, fresh count and depth list ends
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            free_head_reg <= '0;
            fresh_reg     <= '0;
            for (int i = 0; i < DEPTH_LEVELS; i++)
            begin
                level_first_reg[i] <= NONE;
                level_last_reg[i]  <= NONE;
            end
        end
        else
        begin
            free_head_reg <= free_head_next;
            fresh_reg     <= fresh_next;
            if (lf_we)
            begin
                level_first_reg[lf_idx] <= lf_data;
            end
            if (ll_we)
            begin
                level_last_reg[ll_idx] <= ll_data;
            end
        end
    end

    // sequencer and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            item_reg       <= '0;
            out_valid_reg  <= 1'b0;
            new_node_reg   <= '0;
            node_level_reg <= '0;
            prev_reg       <= '0;
            status_reg     <= ST_ALLOC;
        end
        else
        begin
            unique case (state_reg)
                S_IDLE:
                begin
                    if (pop)
                    begin
                        item_reg  <= q_item;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    if (fire)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase

            if (fire)
            begin
                out_valid_reg  <= 1'b1;
                new_node_reg   <= '0;
                node_level_reg <= '0;
                prev_reg       <= PREV_W'(NONE);
                priority if (is_alloc && pool_empty)
                begin
                    status_reg <= ST_EMPTY;
                end
                else if (is_alloc && too_deep)
                begin
                    status_reg <= ST_DEEP;
                end
                else if (is_alloc)
                begin
                    status_reg     <= ST_ALLOC;
                    new_node_reg   <= NODE_W'(free_head_reg);
                    node_level_reg <= LEVEL_W'(ndepth);
                    prev_reg       <= PREV_W'(a_last);
                end
                else
                begin
                    status_reg <= ST_FREED;
                end
            end
            else if (out_valid_reg && !rsp_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign rsp_valid     = out_valid_reg;
    assign new_node      = new_node_reg;
    assign node_level    = node_level_reg;
    assign prev_in_level = prev_reg;
    assign status        = status_reg;

endmodule

// File: design/npl_checker.sv
// npl_port_checks: port-level checks on the response channel of the top level
// depends on npl_pkg; bound to node_pool_depth_lists_top

module npl_port_checks #(
    parameter int POOL_NODES   = npl_pkg::POOL_NODES_DEF,
    parameter int DEPTH_LEVELS = npl_pkg::DEPTH_LEVELS_DEF
) (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          rsp_valid,
    input logic                          rsp_stall,
    input logic [npl_pkg::NODE_W-1:0]    new_node,
    input logic [npl_pkg::LEVEL_W-1:0]   node_level,
    input logic [npl_pkg::PREV_W-1:0]    prev_in_level,
    input logic [npl_pkg::STATUS_W-1:0]  status
);
    import npl_pkg::*;

    // a new node never follows itself in its depth list
    a_prev_differs: assert property (@(posedge clk) disable iff (!rst_n)
        (POOL_NODES <= 256) && rsp_valid && (status == ST_ALLOC)
        |-> PREV_W'(new_node) != prev_in_level)
    else $error("allocated node reported as its own predecessor");

    // results other than an allocation carry the neutral field values
    a_neutral_fields: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status != ST_ALLOC)
        |-> (new_node == '0) && (node_level == '0)
            && (prev_in_level == PREV_W'(POOL_NODES)))
    else $error("non-allocate result with non-neutral fields");

    // an allocated node sits below the root and within the depth range
    a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (status == ST_ALLOC)
        |-> (node_level != '0)
            && ((DEPTH_LEVELS > 16) || (32'(node_level) < 32'(DEPTH_LEVELS))))
    else $error("allocated node level out of range");

    // a stalled response holds
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall
        |=> rsp_valid && $stable(new_node) && $stable(node_level)
            && $stable(prev_in_level) && $stable(status))
    else $error("stalled response changed");

endmodule

bind node_pool_depth_lists_top npl_port_checks #(
    .POOL_NODES   (POOL_NODES),
    .DEPTH_LEVELS (DEPTH_LEVELS)
) u_npl_port_checks (.*);

// File: tb/npl_checker.sv
// npl_checker: watches the request and response channels of the node pool block,
// predicts every response from its own copy of the pool and depth lists, and compares
// depends on npl_pkg for widths, command and status codes
`timescale 1ns / 1ps

module npl_checker
    import npl_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    input  logic                req_stall,
    input  logic [CMD_W-1:0]    cmd,
    input  logic [PARENT_W-1:0] parent_node,
    input  logic [TARGET_W-1:0] target_node,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  logic [NODE_W-1:0]   new_node,
    input  logic [LEVEL_W-1:0]  node_level,
    input  logic [PREV_W-1:0]   prev_in_level,
    input  logic [STATUS_W-1:0] status,
    output int                  mismatch_count,
    output int                  rsp_owed
);

    localparam int POOL   = POOL_NODES_DEF;
    localparam int LEVELS = DEPTH_LEVELS_DEF;
    localparam logic [PREV_W-1:0] NO_NODE = PREV_W'(POOL);

    typedef struct packed {
        logic [NODE_W-1:0]  node;
        logic [LEVEL_W-1:0] level;
        logic [PREV_W-1:0]  prev;
        status_t            st;
    } pool_rsp_t;

    // shadow copy of the pool: free list, per-node links and depth, per-level ends
    logic [PREV_W-1:0]  free_head;
    logic [PREV_W-1:0]  free_link   [POOL];
    logic [PREV_W-1:0]  prev_link   [POOL];
    logic [PREV_W-1:0]  next_link   [POOL];
    logic [LEVEL_W-1:0] node_depth  [POOL];
    logic               in_use      [POOL];
    logic [PREV_W-1:0]  level_first [LEVELS];
    logic [PREV_W-1:0]  level_last  [LEVELS];

    pool_rsp_t rsp_q[$];
    int        err_total;

    // init routine: free list chained 0, 1, 2 and so on, every level empty
    function automatic void pool_reset();
        for (int i = 0; i < POOL; i++)
        begin
            free_link[i]  = PREV_W'(i + 1);
            prev_link[i]  = NO_NODE;
            next_link[i]  = NO_NODE;
            node_depth[i] = '0;
            in_use[i]     = 1'b0;
        end
        for (int d = 0; d < LEVELS; d++)
        begin
            level_first[d] = NO_NODE;
            level_last[d]  = NO_NODE;
        end
        free_head = '0;
    endfunction

    // apply one command to the shadow pool and return the response it gives
    function automatic pool_rsp_t pool_apply(cmd_t op, logic [PARENT_W-1:0] parent,
                                             logic [TARGET_W-1:0] target);
        pool_rsp_t         r;
        int                depth;
        logic [PREV_W-1:0] node;
        logic [PREV_W-1:0] last;
        logic [PREV_W-1:0] p;
        logic [PREV_W-1:0] n;
        r = '{node: '0, level: '0, prev: NO_NODE, st: ST_FREED};
        if (op == CMD_ALLOC)
        begin
            // parent at or above the pool size is the root, depth 0
            depth = ((parent < NO_NODE) ? int'(node_depth[parent[7:0]]) : 0) + 1;
            if (free_head >= NO_NODE)
                r.st = ST_EMPTY;
            else if (depth >= LEVELS)
                r.st = ST_DEEP;
            else
            begin
                node      = free_head;
                free_head = (free_link[node[7:0]] > NO_NODE) ? NO_NODE
                                                             : free_link[node[7:0]];
                node_depth[node[7:0]] = LEVEL_W'(depth);
                in_use[node[7:0]]     = 1'b1;
                // append at the tail of its level list
                last                 = level_last[depth];
                prev_link[node[7:0]] = last;
                next_link[node[7:0]] = NO_NODE;
                if (last < NO_NODE)
                    next_link[last[7:0]] = node;
                else
                    level_first[depth] = node;
                level_last[depth] = node;
                r.node  = node[7:0];
                r.level = LEVEL_W'(depth);
                r.prev  = last;
                r.st    = ST_ALLOC;
            end
        end
        else if (in_use[target])
        begin
            // unlink from its level list, then push onto the free list
            depth = int'(node_depth[target]);
            if (depth < LEVELS)
            begin
                p = prev_link[target];
                n = next_link[target];
                if (p < NO_NODE)
                    next_link[p[7:0]] = n;
                else
                    level_first[depth] = n;
                if (n < NO_NODE)
                    prev_link[n[7:0]] = p;
                else
                    level_last[depth] = p;
            end
            in_use[target]    = 1'b0;
            free_link[target] = free_head;
            free_head         = {1'b0, target};
        end
        return r;
    endfunction

    function automatic void field_check(string name, int want, int got);
        if (want != got)
        begin
            err_total++;
            if (err_total <= 10)
                $display("%0t: %s mismatch, expected %0d, got %0d", $realtime, name, want, got);
        end
    endfunction

    // response side first, then the new request, so a queue slot is never reused early
    always @(posedge clk or negedge rst_n)
    begin : chk_main
        pool_rsp_t want;
        if (!rst_n)
        begin
            pool_reset();
            rsp_q.delete();
            err_total = 0;
            mismatch_count <= 0;
            rsp_owed       <= 0;
        end
        else
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (rsp_q.size() == 0)
                begin
                    err_total++;
                    if (err_total <= 10)
                        $display("%0t: response transaction with none outstanding", $realtime);
                end
                else
                begin
                    want = rsp_q.pop_front();
                    field_check("new_node", want.node, new_node);
                    field_check("node_level", want.level, node_level);
                    field_check("prev_in_level", want.prev, prev_in_level);
                    field_check("status", want.st, status);
                end
            end
            if (req_valid && !req_stall)
                rsp_q.push_back(pool_apply(cmd_t'(cmd), parent_node, target_node));
            mismatch_count <= err_total;
            rsp_owed       <= rsp_q.size();
        end
    end

endmodule

// File: tb/node_pool_depth_lists_top_tb.sv
// node_pool_depth_lists_top_tb: drives allocate and free transactions into the node pool
// block with random idling and stalls; checking is done by npl_checker
// depends on npl_pkg, node_pool_depth_lists_top and npl_checker
`timescale 1ns / 1ps

module node_pool_depth_lists_top_tb;
    import npl_pkg::*;

    localparam int TOP_LEVEL = DEPTH_LEVELS_DEF - 1;

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                req_valid   = 1'b0;
    logic                req_stall;
    logic [CMD_W-1:0]    cmd         = '0;
    logic [PARENT_W-1:0] parent_node = '0;
    logic [TARGET_W-1:0] target_node = '0;
    logic                rsp_valid;
    logic                rsp_stall   = 1'b0;
    logic [NODE_W-1:0]   new_node;
    logic [LEVEL_W-1:0]  node_level;
    logic [PREV_W-1:0]   prev_in_level;
    logic [STATUS_W-1:0] status;

    int mismatch_count;
    int rsp_owed;
    int tx_idle_pct = 26;
    int rx_idle_pct = 72;

    // what the stimulus has learned from responses: written nodes, live nodes, one per level
    logic              seen_node [256] = '{default: 1'b0};
    logic              live_node [256] = '{default: 1'b0};
    int                level_pick [1:TOP_LEVEL] = '{default: -1};
    logic              any_seen  = 1'b0;
    logic [NODE_W-1:0] last_node = '0;

    node_pool_depth_lists_top u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .req_valid    (req_valid),
        .req_stall    (req_stall),
        .cmd          (cmd),
        .parent_node  (parent_node),
        .target_node  (target_node),
        .rsp_valid    (rsp_valid),
        .rsp_stall    (rsp_stall),
        .new_node     (new_node),
        .node_level   (node_level),
        .prev_in_level(prev_in_level),
        .status       (status)
    );

    npl_checker u_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .req_valid     (req_valid),
        .req_stall     (req_stall),
        .cmd           (cmd),
        .parent_node   (parent_node),
        .target_node   (target_node),
        .rsp_valid     (rsp_valid),
        .rsp_stall     (rsp_stall),
        .new_node      (new_node),
        .node_level    (node_level),
        .prev_in_level (prev_in_level),
        .status        (status),
        .mismatch_count(mismatch_count),
        .rsp_owed      (rsp_owed)
    );

    // 12 ns clock
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // random response stall
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= ($urandom_range(0, 99) < rx_idle_pct);
    end

    // learn node indices and depths from allocate responses, drop nodes as frees go in
    always @(posedge clk)
    begin : learn
        logic free_taken;
        free_taken = req_valid && !req_stall && (cmd == CMD_FREE);
        if (rst_n && rsp_valid && !rsp_stall && status == ST_ALLOC)
        begin
            seen_node[new_node] <= 1'b1;
            any_seen            <= 1'b1;
            last_node           <= new_node;
            if (!(free_taken && target_node == new_node))
                live_node[new_node] <= 1'b1;
            if (node_level >= 1 && node_level <= TOP_LEVEL)
                level_pick[node_level] <= int'(new_node);
        end
        if (rst_n && free_taken)
            live_node[target_node] <= 1'b0;
    end

    // present one transaction, after a random gap, and return at the edge that takes it
    task automatic put_cmd(cmd_t op, logic [PARENT_W-1:0] parent, logic [TARGET_W-1:0] target);
        int gap;
        gap = 0;
        while (gap < 8 && $urandom_range(0, 99) < tx_idle_pct)
            gap++;
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_valid   <= 1'b1;
        cmd         <= op;
        parent_node <= parent;
        target_node <= target;
        do
            @(posedge clk);
        while (req_stall);
    endtask

    // hold off the sender until every outstanding response has come back
    task automatic drain();
        req_valid <= 1'b0;
        do
            @(posedge clk);
        while (rsp_owed != 0);
    endtask

    // one random transaction: allocates mostly under known nodes, frees mostly of live ones
    task automatic send_random(int alloc_pct);
        cmd_t                op;
        logic [PARENT_W-1:0] parent;
        logic [TARGET_W-1:0] target;
        int                  pick;
        int                  lvl;
        int                  idx;
        op     = ($urandom_range(0, 99) < alloc_pct) ? CMD_ALLOC : CMD_FREE;
        parent = PARENT_W'($urandom_range(0, 511));
        target = TARGET_W'($urandom_range(0, 255));
        if (op == CMD_ALLOC)
        begin
            parent = PARENT_W'($urandom_range(256, 511));
            pick   = $urandom_range(0, 99);
            if (pick >= 25 && pick < 65)
            begin
                // grow a chain one level at a time, reaching the depth limit now and then
                lvl = $urandom_range(1, TOP_LEVEL);
                if (level_pick[lvl] >= 0)
                    parent = PARENT_W'(level_pick[lvl]);
            end
            else if (pick >= 65 && any_seen)
            begin
                for (int k = 0; k < 32; k++)
                begin
                    idx = $urandom_range(0, 255);
                    if (seen_node[idx])
                    begin
                        parent = PARENT_W'(idx);
                        break;
                    end
                end
            end
        end
        else if ($urandom_range(0, 99) < 75)
        begin
            for (int k = 0; k < 32; k++)
            begin
                idx = $urandom_range(0, 255);
                if (live_node[idx])
                begin
                    target = TARGET_W'(idx);
                    break;
                end
            end
        end
        put_cmd(op, parent, target);
    endtask

    // stimulus and verdict
    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // frees of nodes never handed out are ignored
        put_cmd(CMD_FREE, 9'd0, 8'd0);
        put_cmd(CMD_FREE, 9'd511, 8'd255);
        // three children of the root under different root encodings, nodes 0, 1, 2
        put_cmd(CMD_ALLOC, 9'd256, 8'd0);
        put_cmd(CMD_ALLOC, 9'd511, 8'd255);
        put_cmd(CMD_ALLOC, 9'd300, 8'd170);
        drain();
        // chain down to the deepest level, then one step too deep
        for (int i = 0; i < TOP_LEVEL; i++)
        begin
            put_cmd(CMD_ALLOC, {1'b0, last_node}, 8'd85);
            drain();
        end
        // unlink the middle, then the head, then the tail of the first level
        put_cmd(CMD_FREE, 9'd0, 8'd1);
        put_cmd(CMD_FREE, 9'd0, 8'd0);
        put_cmd(CMD_FREE, 9'd0, 8'd2);
        // the last freed node comes back first, into an empty list
        put_cmd(CMD_ALLOC, 9'd256, 8'd0);
        // free twice, then use the freed node as a parent by its stored depth
        put_cmd(CMD_FREE, 9'd0, 8'd3);
        put_cmd(CMD_FREE, 9'd0, 8'd3);
        put_cmd(CMD_ALLOC, 9'd3, 8'd0);
        drain();

        // sender idles lightly, receiver stalls heavily
        for (int i = 0; i < 120; i++)
            send_random(65);
        drain();

        // the other way round
        tx_idle_pct = 72;
        rx_idle_pct = 26;
        for (int i = 0; i < 120; i++)
            send_random(60);
        drain();

        // no idling: exhaust the pool, then mixed traffic
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        for (int i = 0; i < 280; i++)
            put_cmd(CMD_ALLOC, PARENT_W'($urandom_range(256, 511)),
                    TARGET_W'($urandom_range(0, 255)));
        for (int i = 0; i < 40; i++)
            send_random(45);
        drain();

        repeat (8) @(posedge clk);
        if (mismatch_count == 0 && rsp_owed == 0)
            $display("node_pool_depth_lists_top test passed");
        else
            $display("node_pool_depth_lists_top test failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #5_000_000;
        $display("node_pool_depth_lists_top test failed");
        $finish;
    end

endmodule

// File: sim.f
design/npl_pkg.sv
design/npl_front.sv
design/npl_queue.sv
design/npl_back.sv
design/node_pool_depth_lists_top.sv
design/npl_checker.sv
tb/npl_checker.sv
tb/node_pool_depth_lists_top_tb.sv
